// File: rtl/core/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg: shared types, constants and helpers of the URL percent-decoder
// Character codes, register indexes, queue entry type and hex helpers.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic REG_DECODE_PLUS = 1'b0;
  localparam logic REG_SAFE_MODE   = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    HELD_NONE    = 2'd0,
    HELD_PERCENT = 2'd1,
    HELD_DIGIT   = 2'd2
  } urlpd_held_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
    logic            eos;
  } urlpd_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } urlpd_qstat_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (b <= 8'h39) begin
      return b[3:0];
    end
    return b[3:0] + 4'd9;
  endfunction

  function automatic logic in_quote_class(input logic [7:0] c);
    return c <= 8'h20 || c == 8'h23 || c == 8'h25 || c == 8'h26 ||
           c == 8'h2B || c == 8'h3A || c == 8'h3F || c == 8'h7F;
  endfunction

endpackage

// File: rtl/core/urlpd_if.sv
// ----------------------------------------------------------------------------
// urlpd channel interfaces
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface urlpd_enc_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, in_byte, end_of_string, input ready);
  modport sink   (input valid, in_byte, end_of_string, output ready);
endinterface

interface urlpd_dec_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_done;

  modport source (output valid, out_byte, run_last, string_done, input ready);
  modport sink   (input valid, out_byte, run_last, string_done, output ready);
endinterface

// File: rtl/core/urlpd_front.sv
// ----------------------------------------------------------------------------
// urlpd_front: byte classifier
// Tracks held '%' and first digit, forms up to three output bytes per item.
// ----------------------------------------------------------------------------
module urlpd_front (
  input  logic                 clk,
  input  logic                 rst,
  urlpd_enc_if.sink            enc,
  input  logic                 decode_plus,
  input  logic                 safe_mode,
  input  urlpd_pkg::urlpd_qstat_t qstat,
  output logic                 push,
  output urlpd_pkg::urlpd_job_t push_job
);
  import urlpd_pkg::*;

  urlpd_held_t     held_count, held_count_next;
  urlpd_held_t     held_after;
  logic [7:0]      held_digit, held_digit_next;
  logic [2:0][7:0] e;
  logic [1:0]      k;
  logic            do_fresh;
  logic [7:0]      b;
  logic [7:0]      c;
  logic            accept;

  assign b         = enc.in_byte;
  assign enc.ready = !qstat.full;
  assign accept    = enc.valid && enc.ready;
  assign c         = {hex_val(held_digit), hex_val(b)};

  always_comb begin
    held_after      = held_count;
    held_digit_next = held_digit;
    unique case (held_count)
      HELD_PERCENT: begin
        if (is_hex(b)) begin
          held_after      = HELD_DIGIT;
          held_digit_next = b;
        end else begin
          held_after = (b == CH_PERCENT) ? HELD_PERCENT : HELD_NONE;
        end
      end
      HELD_DIGIT: begin
        held_after = (!is_hex(b) && b == CH_PERCENT) ? HELD_PERCENT : HELD_NONE;
      end
      default: begin
        held_after = (b == CH_PERCENT) ? HELD_PERCENT : HELD_NONE;
      end
    endcase
    held_count_next = enc.end_of_string ? HELD_NONE : held_after;
  end

  always_comb begin
    e        = '0;
    k        = 2'd0;
    do_fresh = 1'b0;
    unique case (held_count)
      HELD_PERCENT: begin
        if (!is_hex(b)) begin
          e[k] = CH_PERCENT;
          k    = k + 2'd1;
          do_fresh = 1'b1;
        end
      end
      HELD_DIGIT: begin
        if (is_hex(b)) begin
          if (safe_mode && !c[7] && in_quote_class(c)) begin
            e[0] = CH_PERCENT;
            e[1] = held_digit;
            e[2] = b;
            k    = 2'd3;
          end else begin
            e[0] = c;
            k    = 2'd1;
          end
        end else begin
          e[0] = CH_PERCENT;
          e[1] = held_digit;
          k    = 2'd2;
          do_fresh = 1'b1;
        end
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase
    if (do_fresh && b != CH_PERCENT) begin
      e[k] = (decode_plus && b == CH_PLUS) ? CH_SPACE : b;
      k    = k + 2'd1;
    end
    if (enc.end_of_string) begin
      if (held_after != HELD_NONE) begin
        e[k] = CH_PERCENT;
        k    = k + 2'd1;
      end
      if (held_after == HELD_DIGIT) begin
        e[k] = held_digit_next;
        k    = k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= HELD_NONE;
      held_digit <= 8'h00;
    end else if (accept) begin
      held_count <= held_count_next;
      held_digit <= held_digit_next;
    end
  end

  assign push           = accept && (k != 2'd0);
  assign push_job.bytes = e;
  assign push_job.count = k;
  assign push_job.eos   = enc.end_of_string;

endmodule

// File: rtl/core/urlpd_queue.sv
// ----------------------------------------------------------------------------
// urlpd_queue: job queue between classifier and emitter
// Small register FIFO of pending output groups.
// ----------------------------------------------------------------------------
module urlpd_queue #(
  parameter int Depth = urlpd_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  urlpd_pkg::urlpd_job_t    push_job,
  input  logic                     pop,
  output urlpd_pkg::urlpd_job_t    head,
  output urlpd_pkg::urlpd_qstat_t  qstat
);
  import urlpd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  urlpd_job_t      mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt;

  assign head        = mem[rd_ptr];
  assign qstat.empty = (cnt == '0);
  assign qstat.full  = (cnt == FullCnt);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CntW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/core/urlpd_back.sv
// ----------------------------------------------------------------------------
// urlpd_back: byte emitter
// Holds one output group and presents its bytes one per cycle while ready.
// ----------------------------------------------------------------------------
module urlpd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  urlpd_pkg::urlpd_job_t   head,
  input  urlpd_pkg::urlpd_qstat_t qstat,
  output logic                    pop,
  urlpd_dec_if.source             dec
);
  import urlpd_pkg::*;

  urlpd_job_t job;
  logic       busy;
  logic [1:0] idx;
  logic       last_byte;
  logic       fire;

  assign last_byte       = (idx == job.count - 2'd1);
  assign fire            = dec.valid && dec.ready;
  assign pop             = !qstat.empty && (!busy || (fire && last_byte));
  assign dec.valid       = busy;
  assign dec.out_byte    = job.bytes[idx];
  assign dec.run_last    = last_byte;
  assign dec.string_done = last_byte && job.eos;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (last_byte) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: streaming URL percent-decoder
// Decodes %XX escapes, optional '+' to space, optional safe-class refusal.
//
//   channel  dir   payload                              handshake
//   enc      in    in_byte, end_of_string               valid/ready
//   dec      out   out_byte, run_last, string_done      valid/ready
//   apb      cfg   decode_plus @0x0, safe_mode @0x4     psel/penable
//
// One input byte is taken per cycle while the job queue has room.
// Each byte yields zero to three output bytes, sent one per cycle by the
// emitter while the dec receiver is ready.
// A group is written into the job queue, then loaded into the emitter.
// Reset clears held bytes, queue and emitter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
  parameter int QueueDepth = urlpd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  urlpd_enc_if.sink   enc,
  urlpd_dec_if.source dec,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import urlpd_pkg::*;

  logic         decode_plus;
  logic         safe_mode;
  logic         cfg_wr;
  logic         push;
  logic         pop;
  urlpd_job_t   push_job;
  urlpd_job_t   head;
  urlpd_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_plus <= 1'b0;
      safe_mode   <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SAFE_MODE) begin
        safe_mode <= pwdata[0];
      end else begin
        decode_plus <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SAFE_MODE) begin
      prdata[0] = safe_mode;
    end else begin
      prdata[0] = decode_plus;
    end
  end

  urlpd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .enc         (enc),
    .decode_plus (decode_plus),
    .safe_mode   (safe_mode),
    .qstat       (qstat),
    .push        (push),
    .push_job    (push_job)
  );

  urlpd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  urlpd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .dec   (dec)
  );

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  a_pop_shows_item: assert property (@(posedge clk) disable iff (rst)
    pop |=> dec.valid)
    else $error("popped group not presented");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    dec.valid && dec.string_done |-> dec.run_last)
    else $error("string_done without run_last");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

endmodule
